// ===== design/clamped_gauss_line_pass_unit_macros.svh =====
// Assertion macros shared by the blur line pass modules.
// Depends on a clock named clock and a synchronous reset named reset in the user module.
`ifndef CLAMPED_GAUSS_LINE_PASS_UNIT_MACROS_SVH
`define CLAMPED_GAUSS_LINE_PASS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CGLP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CGLP_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define CGLP_ASSERT(label, prop, msg)
`define CGLP_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== design/cglp_pkg.sv =====
// Types and constants of the blur line pass.
// No dependencies; imported by cglp_seq, cglp_mac and the top module.
`timescale 1ns / 1ps

package cglp_pkg;

   localparam int MAX_RADIUS = 31;
   localparam int TAP_COUNT  = 2 * MAX_RADIUS + 1;
   localparam int ADDR_W     = 6;
   localparam int RAD_W      = 5;
   localparam int COEF_W     = 17;
   localparam int CHAN_W     = 8;
   localparam int CHANNELS   = 4;
   localparam int PIX_W      = CHANNELS * CHAN_W;
   localparam int PROD_W     = CHAN_W + COEF_W;
   localparam int ACC_W      = 31;
   localparam int FRAC_W     = 16;

   localparam logic [ADDR_W-1:0] WIN_LAST = ADDR_W'(TAP_COUNT - 1);

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_COEF  = 1'b1;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [PIX_W-1:0]  pixel_type;

   typedef struct packed {
      logic tap_valid;
      logic use_first;
      logic clear;
   } mac_ctrl_type;

   typedef struct packed {
      logic emit;
      logic end_of_line;
      logic last_of_run;
   } emit_type;

endpackage

// ===== design/cglp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cglp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 63
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/cglp_seq.sv =====
// Sequencer of the blur line pass: line position, window pointer, tap loop, window addressing.
// Depends on cglp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "clamped_gauss_line_pass_unit_macros.svh"

module cglp_seq import cglp_pkg::*; #(
   parameter int MAX_LINE = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic              req_last_in_line,
   input  logic [ADDR_W-1:0] req_coef_index,
   input  logic [RAD_W-1:0]  radius,
   input  logic              mac_busy,
   input  logic              rsp_free,
   output logic              win_we,
   output logic [ADDR_W-1:0] win_waddr,
   output logic [ADDR_W-1:0] win_raddr,
   output logic              coef_we,
   output logic [ADDR_W-1:0] coef_raddr,
   output logic              first_we,
   output mac_ctrl_type      mac_ctrl,
   output emit_type          emit
);

   localparam int LINE_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
   localparam int CMP_W  = (LINE_W > 7) ? LINE_W : 7;
   localparam logic [LINE_W-1:0] LINE_SAT = LINE_W'(MAX_LINE - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_TAP   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [LINE_W-1:0] line_pos_ff, line_pos_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [LINE_W-1:0] n_ff, n_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic              last_ff, last_in;
   logic [RAD_W-1:0]  d_ff, d_in;
   logic [ADDR_W-1:0] tap_ff, tap_in;

   logic              accept;
   logic              pix_acc;
   logic              pos_ge_r;
   logic [ADDR_W-1:0] tap_end;
   logic signed [7:0] back_s;
   logic [6:0]        back_z;
   logic [ADDR_W-1:0] back_c;
   logic [6:0]        slot_diff;
   logic              use_first;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign pix_acc   = accept && (req_cmd == CMD_PIXEL);
   assign pos_ge_r  = CMP_W'(line_pos_ff) >= CMP_W'(radius);
   assign tap_end   = {radius, 1'b0};

   assign win_we     = pix_acc;
   assign win_waddr  = wp_ff;
   assign coef_we    = accept && (req_cmd == CMD_COEF) && (req_coef_index <= WIN_LAST);
   assign coef_raddr = tap_ff;
   assign first_we   = pix_acc && (line_pos_ff == '0);

   // distance back from the newest pixel, clamped to the line ends
   always_comb begin
      back_s    = $signed({3'b000, d_ff}) + $signed({2'b00, tap_ff}) - $signed({3'b000, radius});
      back_z    = back_s[7] ? 7'd0 : back_s[6:0];
      use_first = CMP_W'(back_z) >= CMP_W'(n_ff);
      back_c    = (back_z > 7'(WIN_LAST)) ? WIN_LAST : back_z[ADDR_W-1:0];
      slot_diff = {1'b0, slot_ff} - {1'b0, back_c};
      win_raddr = slot_diff[6] ? ADDR_W'(slot_diff + 7'(TAP_COUNT)) : slot_diff[ADDR_W-1:0];
   end

   always_comb begin
      state_in    = state_ff;
      line_pos_in = line_pos_ff;
      wp_in       = wp_ff;
      n_in        = n_ff;
      slot_in     = slot_ff;
      last_in     = last_ff;
      d_in        = d_ff;
      tap_in      = tap_ff;
      mac_ctrl    = '0;
      emit        = '0;
      case (state_ff)
         ST_IDLE: begin
            mac_ctrl.clear = 1'b1;
            if (pix_acc) begin
               n_in    = line_pos_ff;
               slot_in = wp_ff;
               last_in = req_last_in_line;
               tap_in  = '0;
               if (req_last_in_line && !pos_ge_r) begin
                  d_in = RAD_W'(line_pos_ff);
               end else begin
                  d_in = radius;
               end
               if (req_last_in_line) begin
                  line_pos_in = '0;
                  wp_in       = '0;
               end else begin
                  if (line_pos_ff < LINE_SAT) begin
                     line_pos_in = line_pos_ff + 1'b1;
                  end
                  wp_in = (wp_ff == WIN_LAST) ? '0 : wp_ff + 1'b1;
               end
               if (req_last_in_line || pos_ge_r) begin
                  state_in = ST_TAP;
               end
            end
         end
         ST_TAP: begin
            mac_ctrl.tap_valid = 1'b1;
            mac_ctrl.use_first = use_first;
            if (tap_ff == tap_end) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               emit.emit        = 1'b1;
               emit.end_of_line = last_ff && (d_ff == '0);
               emit.last_of_run = !last_ff || (d_ff == '0);
               mac_ctrl.clear   = 1'b1;
               if (last_ff && (d_ff != '0)) begin
                  d_in     = d_ff - 1'b1;
                  tap_in   = '0;
                  state_in = ST_TAP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         line_pos_ff <= '0;
         wp_ff       <= '0;
         d_ff        <= '0;
         tap_ff      <= '0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         line_pos_ff <= line_pos_in;
         wp_ff       <= wp_in;
         d_ff        <= d_in;
         tap_ff      <= tap_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      slot_ff <= slot_in;
   end

   `CGLP_ASSERT(a_tap_bound, (state_ff == ST_TAP) |-> (tap_ff <= tap_end), "tap past kernel end")
   `CGLP_ASSERT(a_tap_to_drain, (state_ff == ST_TAP && tap_ff == tap_end) |=> (state_ff == ST_DRAIN), "no drain after last tap")
   `CGLP_ASSERT_NEVER(a_emit_busy, emit.emit && mac_busy, "result taken while MAC still busy")
   `CGLP_ASSERT(a_d_bound, (state_ff != ST_IDLE) |-> (d_ff <= radius), "output offset beyond radius")

endmodule

// ===== design/cglp_mac.sv =====
// Shared four-lane multiply-accumulate unit, one tap per cycle, with truncation and saturation.
// Depends on cglp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "clamped_gauss_line_pass_unit_macros.svh"

module cglp_mac import cglp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctrl_type                  mac_ctrl,
   input  pixel_type                     win_rdata,
   input  logic [COEF_W-1:0]             coef_rdata,
   input  pixel_type                     first_pixel,
   output logic                          mac_busy,
   output logic [CHANNELS-1:0][CHAN_W-1:0] result
);

   logic                               v1_ff, v2_ff;
   logic                               use_first1_ff;
   logic [CHANNELS-1:0][PROD_W-1:0]    prod_ff, prod_in;
   logic [CHANNELS-1:0][ACC_W-1:0]     acc_ff, acc_in;
   pixel_type                          px;
   logic [CHANNELS-1:0][ACC_W-FRAC_W-1:0] whole;

   assign px       = use_first1_ff ? first_pixel : win_rdata;
   assign mac_busy = v1_ff || v2_ff;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         prod_in[c] = PROD_W'(px[c*CHAN_W +: CHAN_W]) * PROD_W'(coef_rdata);
         if (mac_ctrl.clear) begin
            acc_in[c] = '0;
         end else if (v2_ff) begin
            acc_in[c] = acc_ff[c] + ACC_W'(prod_ff[c]);
         end else begin
            acc_in[c] = acc_ff[c];
         end
         whole[c]  = acc_ff[c][ACC_W-1:FRAC_W];
         result[c] = (|whole[c][ACC_W-FRAC_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : whole[c][CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= mac_ctrl.tap_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      use_first1_ff <= mac_ctrl.use_first;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
   end

   `CGLP_ASSERT(a_v2_follows, v1_ff |=> v2_ff, "product stage lost a tap")
   `CGLP_ASSERT_NEVER(a_clear_collide, mac_ctrl.clear && v2_ff, "accumulator cleared during a tap")
   `CGLP_ASSERT(a_acc_hold, (!v2_ff && !mac_ctrl.clear) |=> $stable(acc_ff), "accumulator moved without a tap")

endmodule

// ===== design/clamped_gauss_line_pass_unit.sv =====
// Operation: a coefficient load leaves ready high; a pixel that yields k outputs runs, per output,
// every kernel tap through the shared four-lane MAC at one tap per cycle, then drain and emit.
// Throughput: one request at a time; ready is low from acceptance of a pixel that yields outputs
// until its last result goes to the output register, which then waits for rsp_ready on its own.
// Reset: radius, line position and window pointer return to zero; coefficient and window RAMs are
// not cleared and hold whatever was last written.
`timescale 1ns / 1ps

module clamped_gauss_line_pass_unit import cglp_pkg::*; #(
   parameter int MAX_LINE = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [CHAN_W-1:0]   req_in_red,
   input  logic [CHAN_W-1:0]   req_in_green,
   input  logic [CHAN_W-1:0]   req_in_blue,
   input  logic [CHAN_W-1:0]   req_in_alpha,
   input  logic                req_last_in_line,
   input  logic [ADDR_W-1:0]   req_coef_index,
   input  logic [COEF_W-1:0]   req_coef_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CHAN_W-1:0]   rsp_out_red,
   output logic [CHAN_W-1:0]   rsp_out_green,
   output logic [CHAN_W-1:0]   rsp_out_blue,
   output logic [CHAN_W-1:0]   rsp_out_alpha,
   output logic                rsp_end_of_line,
   output logic                rsp_last_of_run,
   input  logic                csr_we,
   input  logic [RAD_W-1:0]    csr_wdata
);

   logic [RAD_W-1:0]  radius_ff;
   pixel_type         first_pixel_ff;
   pixel_type         req_pixel;

   logic              win_we, coef_we, first_we;
   logic [ADDR_W-1:0] win_waddr, win_raddr, coef_raddr;
   pixel_type         win_rdata;
   logic [COEF_W-1:0] coef_rdata;
   logic              mac_busy;
   logic              rsp_free;
   mac_ctrl_type      mac_ctrl;
   emit_type          emit;
   logic [CHANNELS-1:0][CHAN_W-1:0] result;

   logic              rsp_valid_ff;
   chan_type          red_ff, green_ff, blue_ff, alpha_ff;
   logic              eol_ff, lor_ff;

   assign req_pixel = {req_in_alpha, req_in_blue, req_in_green, req_in_red};
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   cglp_seq #(
      .MAX_LINE (MAX_LINE)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_last_in_line (req_last_in_line),
      .req_coef_index   (req_coef_index),
      .radius           (radius_ff),
      .mac_busy         (mac_busy),
      .rsp_free         (rsp_free),
      .win_we           (win_we),
      .win_waddr        (win_waddr),
      .win_raddr        (win_raddr),
      .coef_we          (coef_we),
      .coef_raddr       (coef_raddr),
      .first_we         (first_we),
      .mac_ctrl         (mac_ctrl),
      .emit             (emit)
   );

   cglp_ram #(
      .WIDTH (PIX_W),
      .DEPTH (TAP_COUNT)
   ) u_win_ram (
      .clock (clock),
      .we    (win_we),
      .waddr (win_waddr),
      .wdata (req_pixel),
      .raddr (win_raddr),
      .rdata (win_rdata)
   );

   cglp_ram #(
      .WIDTH (COEF_W),
      .DEPTH (TAP_COUNT)
   ) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (req_coef_index),
      .wdata (req_coef_value),
      .raddr (coef_raddr),
      .rdata (coef_rdata)
   );

   cglp_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .mac_ctrl    (mac_ctrl),
      .win_rdata   (win_rdata),
      .coef_rdata  (coef_rdata),
      .first_pixel (first_pixel_ff),
      .mac_busy    (mac_busy),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            radius_ff <= csr_wdata;
         end
         if (emit.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_pixel_ff <= req_pixel;
      end
      if (emit.emit) begin
         red_ff   <= result[0];
         green_ff <= result[1];
         blue_ff  <= result[2];
         alpha_ff <= result[3];
         eol_ff   <= emit.end_of_line;
         lor_ff   <= emit.last_of_run;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_red     = red_ff;
   assign rsp_out_green   = green_ff;
   assign rsp_out_blue    = blue_ff;
   assign rsp_out_alpha   = alpha_ff;
   assign rsp_end_of_line = eol_ff;
   assign rsp_last_of_run = lor_ff;

endmodule
